[rtl/asegf_pkg.sv]
// Shared types, constants and helper functions of the seven-segment formatter.
`default_nettype none

package asegf_pkg;

  // Reciprocal of 1000 scaled by 2^41: exact floor division for any 32-bit dividend
  localparam logic [31:0] RECIP_1000  = 32'd2199023256;
  localparam int          RECIP_SHIFT = 41;
  localparam logic [31:0] THOUSAND    = 32'd1000;
  localparam logic [32:0] MILLION     = 33'd1000000;

  // Segment bit of the decimal point in this board's bit order
  localparam logic [7:0] SEG_POINT = 8'h04;

  // Digit glyphs: F=0, B=1, point=2, C=3, A=4, D=5, E=6, G=7
  localparam logic [7:0] DIGIT_GLYPH [10] = '{
    8'h7B, 8'h0A, 8'hF2, 8'hBA, 8'h8B, 8'hB9, 8'hF9, 8'h1A, 8'hFB, 8'hBB
  };

  localparam logic [3:0] BLANK_DIGIT = 4'hF;

  typedef enum logic [1:0] {
    MODE_INT      = 2'd0,
    MODE_ONES     = 2'd1,
    MODE_TENS     = 2'd2,
    MODE_HUNDREDS = 2'd3
  } disp_mode_t;

  // Integer and fraction split of one request
  typedef struct packed {
    disp_mode_t  mode;
    logic        overflow;
    logic [3:0]  lead;
    logic [9:0]  int_lo;
    logic [9:0]  frac;
  } split_t;

  // Four digits, left first, with a one-hot point position
  typedef struct packed {
    logic [3:0][3:0] digit;
    logic [3:0]      point;
    logic            overflow;
  } digits_t;

  // Hundreds, tens and ones of a value below 1000
  function automatic logic [11:0] bcd3(input logic [9:0] x);
    logic [15:0] hp;
    logic [3:0]  h;
    logic [9:0]  rw;
    logic [6:0]  r;
    logic [13:0] tp;
    logic [3:0]  t;
    logic [6:0]  ow;
    hp = 16'(x) * 16'd41;
    h  = hp[15:12];
    rw = x - 10'(10'(h) * 10'd100);
    r  = rw[6:0];
    tp = 14'(r) * 14'd103;
    t  = tp[13:10];
    ow = r - 7'(7'(t) * 7'd10);
    return {h, t, ow[3:0]};
  endfunction

  // Segment byte of one digit; codes above nine show at most the point
  function automatic logic [7:0] glyph(input logic [3:0] d, input logic pt);
    logic [7:0] g;
    g = pt ? SEG_POINT : 8'h00;
    if (d <= 4'd9) begin
      g = g | DIGIT_GLYPH[d];
    end
    return g;
  endfunction

endpackage

`default_nettype wire

[rtl/autorange_seven_segment_formatter_unit.sv]
// Throughput: one request per cycle without a result stall; two reciprocal multiplies
// by 1000 and one digit split set the stage boundaries of the five-stage pipeline.
// A stall on the result side holds every occupied stage; empty stages still fill.
// Reset (synchronous, active high) clears the valid bits only; payload is not reset.
`default_nettype none

module autorange_seven_segment_formatter_unit
  import asegf_pkg::*;
#(
  parameter int VALUE_BITS = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  value_valid,
  output logic                       value_stall,
  input  wire logic [VALUE_BITS-1:0] value_thousandths,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output logic [7:0]                 left_segments,
  output logic [7:0]                 second_segments,
  output logic [7:0]                 third_segments,
  output logic [7:0]                 right_segments,
  output logic                       overflow
);

  logic    split_valid;
  logic    split_stall;
  split_t  split;
  logic    digit_valid;
  logic    digit_stall;
  digits_t digits;

  // Integer and fraction split
  asegf_divide #(
    .VALUE_BITS(VALUE_BITS)
  ) u_divide (
    .clk              (clk),
    .rst              (rst),
    .value_valid      (value_valid),
    .value_stall      (value_stall),
    .value_thousandths(value_thousandths),
    .split_valid      (split_valid),
    .split_stall      (split_stall),
    .split            (split)
  );

  // Decimal digits per position
  asegf_digits u_digits (
    .clk        (clk),
    .rst        (rst),
    .split_valid(split_valid),
    .split_stall(split_stall),
    .split      (split),
    .digit_valid(digit_valid),
    .digit_stall(digit_stall),
    .digits     (digits)
  );

  // Segment encoding and output register
  asegf_encode u_encode (
    .clk            (clk),
    .rst            (rst),
    .digit_valid    (digit_valid),
    .digit_stall    (digit_stall),
    .digits         (digits),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .left_segments  (left_segments),
    .second_segments(second_segments),
    .third_segments (third_segments),
    .right_segments (right_segments),
    .overflow       (overflow)
  );

`ifndef SYNTHESIS
  // A blanked leading digit shows nothing
  a_blank_on_overflow: assert property (@(posedge clk) disable iff (rst)
    result_valid && overflow |-> left_segments == 8'h00)
    else $error("leading position not blank on overflow");

  // Exactly one decimal point on the display
  a_one_point: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $countones({left_segments[2], second_segments[2],
                                 third_segments[2], right_segments[2]}) == 1)
    else $error("decimal point count is not one");

  // Overflow only arises in the integer mode, point on the right
  a_overflow_int_mode: assert property (@(posedge clk) disable iff (rst)
    result_valid && overflow |-> right_segments[2])
    else $error("overflow outside integer mode");

  // Without overflow the leading position always shows a digit
  a_lead_shown: assert property (@(posedge clk) disable iff (rst)
    result_valid && !overflow |-> left_segments != 8'h00)
    else $error("leading digit missing");
`endif

endmodule

`default_nettype wire

[rtl/asegf_divide.sv]
// Three-stage split of the value into integer and thousandths parts, with mode choice.
`default_nettype none

module asegf_divide
  import asegf_pkg::*;
#(
  parameter int VALUE_BITS = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  value_valid,
  output logic                       value_stall,
  input  wire logic [VALUE_BITS-1:0] value_thousandths,
  output logic                       split_valid,
  input  wire logic                  split_stall,
  output split_t                     split
);

  localparam int PROD_BITS = VALUE_BITS + 32;
  localparam int IP_BITS   = VALUE_BITS - 9;
  localparam int HI_BITS   = (VALUE_BITS > 20) ? VALUE_BITS - 19 : 1;

  logic ready1, ready2, ready3;
  logic valid1, valid2;

  // Stage 1 registers
  logic [VALUE_BITS-1:0] v1;
  logic [IP_BITS-1:0]    ip1;
  logic                  gtm1;

  // Stage 2 registers
  logic [IP_BITS-1:0]    ip2;
  logic [HI_BITS-1:0]    ip_hi2;
  logic [9:0]            fr2;
  logic                  gtm2;
  logic                  lt10_2;
  logic                  lt100_2;

  logic [PROD_BITS-1:0]  prod_v;
  logic [PROD_BITS-1:0]  prod_ip;
  logic [VALUE_BITS-1:0] ip_k;
  logic [VALUE_BITS-1:0] fr_wide;
  logic [31:0]           lo_wide;
  logic                  int_mode;
  logic                  ovf;
  split_t                split_next;

  // Move a stage when it is empty or its successor moves
  assign ready3      = !split_valid || !split_stall;
  assign ready2      = !valid2 || ready3;
  assign ready1      = !valid1 || ready2;
  assign value_stall = !ready1;

  // Stage 1: quotient by reciprocal multiply
  assign prod_v = PROD_BITS'(value_thousandths) * PROD_BITS'(RECIP_1000);

  // Stage 2: thousandths remainder and the thousands of the integer part
  assign ip_k    = VALUE_BITS'(PROD_BITS'(ip1) * PROD_BITS'(THOUSAND));
  assign fr_wide = v1 - ip_k;
  assign prod_ip = PROD_BITS'(ip1) * PROD_BITS'(RECIP_1000);

  // Stage 3: integer part below 1000 and display mode
  assign lo_wide  = 32'(ip2) - 32'(32'(ip_hi2) * THOUSAND);
  assign int_mode = (fr2 == 10'd0) || gtm2;
  assign ovf      = int_mode && (32'(ip_hi2) >= 32'd10);

  always_comb begin
    split_next.int_lo   = lo_wide[9:0];
    split_next.frac     = fr2;
    split_next.overflow = ovf;
    split_next.lead     = ovf ? BLANK_DIGIT : 4'(ip_hi2);
    if (int_mode) begin
      split_next.mode = MODE_INT;
    end else if (lt10_2) begin
      split_next.mode = MODE_ONES;
    end else if (lt100_2) begin
      split_next.mode = MODE_TENS;
    end else begin
      split_next.mode = MODE_HUNDREDS;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1      <= 1'b0;
      valid2      <= 1'b0;
      split_valid <= 1'b0;
    end else begin
      if (ready1) valid1 <= value_valid;
      if (ready2) valid2 <= valid1;
      if (ready3) split_valid <= valid2;
    end
  end

  // Advance payload; hold while stalled
  always_ff @(posedge clk) begin
    if (ready1) begin
      v1   <= value_thousandths;
      ip1  <= prod_v[RECIP_SHIFT +: IP_BITS];
      gtm1 <= 33'(value_thousandths) > MILLION;
    end
    if (ready2) begin
      ip2     <= ip1;
      ip_hi2  <= prod_ip[RECIP_SHIFT +: HI_BITS];
      fr2     <= fr_wide[9:0];
      gtm2    <= gtm1;
      lt10_2  <= 32'(ip1) < 32'd10;
      lt100_2 <= 32'(ip1) < 32'd100;
    end
    if (ready3) begin
      split <= split_next;
    end
  end

endmodule

`default_nettype wire

[rtl/asegf_digits.sv]
// Digit stage: decimal digits and point position for the chosen display mode.
`default_nettype none

module asegf_digits
  import asegf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    split_valid,
  output logic         split_stall,
  input  wire split_t  split,
  output logic         digit_valid,
  input  wire logic    digit_stall,
  output digits_t      digits
);

  logic       ready;
  logic [11:0] lo_bcd;
  logic [11:0] fr_bcd;
  digits_t    digits_next;

  assign ready       = !digit_valid || !digit_stall;
  assign split_stall = !ready;

  assign lo_bcd = bcd3(split.int_lo);
  assign fr_bcd = bcd3(split.frac);

  // Pick the digits of each position, left first
  always_comb begin
    digits_next.overflow = split.overflow;
    unique case (split.mode)
      MODE_INT: begin
        digits_next.digit = {split.lead, lo_bcd[11:8], lo_bcd[7:4], lo_bcd[3:0]};
        digits_next.point = 4'b1000;
      end
      MODE_ONES: begin
        digits_next.digit = {lo_bcd[3:0], fr_bcd[11:8], fr_bcd[7:4], fr_bcd[3:0]};
        digits_next.point = 4'b0001;
      end
      MODE_TENS: begin
        digits_next.digit = {lo_bcd[7:4], lo_bcd[3:0], fr_bcd[11:8], fr_bcd[7:4]};
        digits_next.point = 4'b0010;
      end
      default: begin
        digits_next.digit = {lo_bcd[11:8], lo_bcd[7:4], lo_bcd[3:0], fr_bcd[11:8]};
        digits_next.point = 4'b0100;
      end
    endcase
  end

  // Advance valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_valid <= 1'b0;
    end else if (ready) begin
      digit_valid <= split_valid;
    end
  end

  // Advance payload; hold while stalled
  always_ff @(posedge clk) begin
    if (ready) begin
      digits <= digits_next;
    end
  end

endmodule

`default_nettype wire

[rtl/asegf_encode.sv]
// Output stage: segment bytes of the four positions and the overflow flag.
`default_nettype none

module asegf_encode
  import asegf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    digit_valid,
  output logic         digit_stall,
  input  wire digits_t digits,
  output logic         result_valid,
  input  wire logic    result_stall,
  output logic [7:0]   left_segments,
  output logic [7:0]   second_segments,
  output logic [7:0]   third_segments,
  output logic [7:0]   right_segments,
  output logic         overflow
);

  logic ready;

  assign ready       = !result_valid || !result_stall;
  assign digit_stall = !ready;

  // Advance valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ready) begin
      result_valid <= digit_valid;
    end
  end

  // Encode glyphs; a blanked leading digit carries a code above nine
  always_ff @(posedge clk) begin
    if (ready) begin
      left_segments   <= glyph(digits.digit[3], digits.point[0]);
      second_segments <= glyph(digits.digit[2], digits.point[1]);
      third_segments  <= glyph(digits.digit[1], digits.point[2]);
      right_segments  <= glyph(digits.digit[0], digits.point[3]);
      overflow        <= digits.overflow;
    end
  end

endmodule

`default_nettype wire

[dv/autorange_seven_segment_formatter_unit_tb.sv]
// Self-checking testbench of the seven-segment formatter, with randomised requests and stalls.
`default_nettype none

module autorange_seven_segment_formatter_unit_tb;

  localparam int VALUE_BITS = 24;
  localparam int RANDOM_ITEMS = 450;
  localparam int TAIL_ITEMS = 40;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 12;
  localparam logic [7:0] POINT_BIT = 8'h04;

  // Segment patterns of the digits zero to nine in board order
  localparam logic [7:0] SEG_TABLE [10] = '{
    8'h7B, 8'h0A, 8'hF2, 8'hBA, 8'h8B, 8'hB9, 8'hF9, 8'h1A, 8'hFB, 8'hBB
  };

  typedef struct packed {
    logic [7:0] left_seg;
    logic [7:0] second_seg;
    logic [7:0] third_seg;
    logic [7:0] right_seg;
    logic       ovf;
  } display_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  value_valid = 1'b0;
  logic                  value_stall;
  logic [VALUE_BITS-1:0] value_thousandths = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic [7:0]            left_segments;
  logic [7:0]            second_segments;
  logic [7:0]            third_segments;
  logic [7:0]            right_segments;
  logic                  overflow;

  logic [VALUE_BITS-1:0] pending_values [$];
  display_t              expected_displays [$];
  logic                  tail_phase = 1'b0;
  int                    error_count = 0;
  int                    quiet_cycles = 0;
  int                    send_gap = 0;
  int                    stall_left = 0;

  autorange_seven_segment_formatter_unit #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .value_valid(value_valid),
    .value_stall(value_stall),
    .value_thousandths(value_thousandths),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .left_segments(left_segments),
    .second_segments(second_segments),
    .third_segments(third_segments),
    .right_segments(right_segments),
    .overflow(overflow)
  );

  // Segment byte of one digit; anything above nine lights at most the point
  function automatic logic [7:0] digit_segments(input int unsigned d, input logic pt);
    logic [7:0] g;
    g = pt ? POINT_BIT : 8'h00;
    if (d <= 9) begin
      g = g | SEG_TABLE[d[3:0]];
    end
    return g;
  endfunction

  // Work out the four segment bytes and the overflow flag of one value
  function automatic display_t format_value(input logic [VALUE_BITS-1:0] v);
    int unsigned whole;
    int unsigned frac;
    int unsigned dg [4];
    int          pt;
    display_t    r;
    whole = v / 1000;
    frac  = v % 1000;
    if (frac == 0 || v > 1000000) begin
      dg = '{whole / 1000, (whole / 100) % 10, (whole / 10) % 10, whole % 10};
      pt = 3;
    end else if (whole < 10) begin
      dg = '{whole, frac / 100, (frac / 10) % 10, frac % 10};
      pt = 0;
    end else if (whole < 100) begin
      dg = '{whole / 10, whole % 10, frac / 100, (frac / 10) % 10};
      pt = 1;
    end else begin
      dg = '{whole / 100, (whole / 10) % 10, whole % 10, frac / 100};
      pt = 2;
    end
    r.left_seg   = (dg[0] > 9) ? 8'h00 : digit_segments(dg[0], pt == 0);
    r.second_seg = digit_segments(dg[1], pt == 1);
    r.third_seg  = digit_segments(dg[2], pt == 2);
    r.right_seg  = digit_segments(dg[3], pt == 3);
    r.ovf        = (dg[0] > 9);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endtask

  // Clock
  initial begin
    forever #4 clk = ~clk;
  end

  // Driver: present queued requests, with random gaps outside the tail
  always @(posedge clk) begin
    if (rst) begin
      value_valid <= 1'b0;
      send_gap = 0;
    end else begin
      tail_phase <= (pending_values.size() <= TAIL_ITEMS);
      if (!value_valid || !value_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          value_valid <= 1'b0;
        end else if (pending_values.size() == 0) begin
          value_valid <= 1'b0;
        end else if (pending_values.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(1, 10) - 1;
          value_valid <= 1'b0;
        end else begin
          value_valid <= 1'b1;
          value_thousandths <= pending_values.pop_front();
        end
      end
    end
  end

  // Monitor: check each result, record the prediction of each accepted request
  always @(posedge clk) begin
    display_t want;
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_displays.size() == 0) begin
          $error("result with no request outstanding");
          error_count++;
        end else begin
          want = expected_displays.pop_front();
          check_field("left_segments", want.left_seg, left_segments);
          check_field("second_segments", want.second_seg, second_segments);
          check_field("third_segments", want.third_seg, third_segments);
          check_field("right_segments", want.right_seg, right_segments);
          check_field("overflow", 8'(want.ovf), 8'(overflow));
        end
      end
      if (value_valid && !value_stall) begin
        expected_displays.push_back(format_value(value_thousandths));
      end
      // Hold the result side in random bursts until the tail
      if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Watchdog: drop the run when nothing moves for too long
  always @(posedge clk) begin
    if ((value_valid && !value_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    logic [VALUE_BITS-1:0] v;
    // Boundaries of every display mode and of the blanked leading digit
    pending_values = '{
      24'd0, 24'd1, 24'd999, 24'd1000, 24'd1001, 24'd9999,
      24'd10000, 24'd10001, 24'd99999, 24'd100000, 24'd100001, 24'd999999,
      24'd999001, 24'd1000000, 24'd1000001, 24'd9999000, 24'd9999999,
      24'd10000000, 24'd10000001, 24'd16777215, 24'd16777000, 24'd8388608,
      24'd123456, 24'd45678, 24'd7890
    };
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ($urandom_range(0, 9))
        2: v = VALUE_BITS'($urandom_range(0, 9999));
        3: v = VALUE_BITS'($urandom_range(10000, 99999));
        4: v = VALUE_BITS'($urandom_range(100000, 999999));
        5: v = VALUE_BITS'($urandom_range(0, 16777) * 1000);
        6: v = VALUE_BITS'($urandom_range(999000, 1002000));
        7: v = VALUE_BITS'($urandom_range(9990000, 10010000));
        8: v = VALUE_BITS'($urandom_range(0, 999) * 1000 + $urandom_range(1, 9));
        default: v = VALUE_BITS'($urandom);
      endcase
      pending_values.push_back(v);
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // Wait for every request to be sent and answered, then let the pipeline settle
    forever begin
      @(negedge clk);
      if (pending_values.size() == 0 && !value_valid && expected_displays.size() == 0) begin
        break;
      end
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0 && expected_displays.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[autorange_seven_segment_formatter_unit.f]
rtl/asegf_pkg.sv
rtl/asegf_divide.sv
rtl/asegf_digits.sv
rtl/asegf_encode.sv
rtl/autorange_seven_segment_formatter_unit.sv
dv/autorange_seven_segment_formatter_unit_tb.sv
